// ----- rtl/four_channel_limit_debounce_macros.svh -----
// Assertion macros shared by the debouncer RTL.
`ifndef FOUR_CHANNEL_LIMIT_DEBOUNCE_MACROS_SVH
`define FOUR_CHANNEL_LIMIT_DEBOUNCE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define FCLD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define FCLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/fcld_pkg.sv -----
// Package with widths, register map and result type for the limit debouncer.
package fcld_pkg;

   localparam int CHANNELS      = 4;
   localparam int COUNT_W       = 8;
   localparam int DEBOUNCE_W    = 8;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   localparam logic [COUNT_W-1:0]    COUNT_MAX      = {COUNT_W{1'b1}};
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(10);

   // Register index (byte address bits above the word offset)
   localparam logic REG_DEBOUNCE_TICKS = 1'b0;

   typedef struct packed {
      logic [CHANNELS-1:0] debounced_levels;
      logic [CHANNELS-1:0] fault_channels;
      logic                fault;
      logic [CHANNELS-1:0] settling_mask;
   } result_type;

endpackage

// ----- rtl/fcld_req_if.sv -----
// Input channel interface: one transaction per 1 ms tick.
interface fcld_req_if;
   logic                          valid;
   logic                          ready;
   logic [fcld_pkg::CHANNELS-1:0] raw_levels;
   logic                          wake_event;

   modport source (output valid, output raw_levels, output wake_event, input ready);
   modport sink   (input valid, input raw_levels, input wake_event, output ready);
endinterface

// ----- rtl/fcld_rsp_if.sv -----
// Result channel interface: debounced levels, faults and settling status.
interface fcld_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fcld_pkg::CHANNELS-1:0] debounced_levels;
   logic [fcld_pkg::CHANNELS-1:0] fault_channels;
   logic                          fault;
   logic [fcld_pkg::CHANNELS-1:0] settling_mask;

   modport source (output valid, output debounced_levels, output fault_channels,
                   output fault, output settling_mask, input ready);
   modport sink   (input valid, input debounced_levels, input fault_channels,
                   input fault, input settling_mask, output ready);
endinterface

// ----- rtl/four_channel_limit_debounce.sv -----
// An accepted tick's result is registered in the result register or skid.
// Throughput: one tick per clock; per-channel state updates in a single pass.
// A two-entry output buffer (result register plus skid) keeps input open while a
// result waits; input stalls only when both entries are full.
// Reset (synchronous, active high): all channel state low/clear/zero,
// debounce_ticks = 10, output buffer empty.
`include "four_channel_limit_debounce_macros.svh"

module four_channel_limit_debounce (
   input  logic                                clock,
   input  logic                                reset,
   fcld_req_if.sink                            req_chan,
   fcld_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fcld_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [fcld_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [fcld_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int CH = fcld_pkg::CHANNELS;

   // Channel state
   logic [CH-1:0]                      sampled_ff, sampled_in;
   logic [CH-1:0]                      stable_ff, stable_in;
   logic [CH-1:0]                      settling_ff, settling_in;
   logic [CH-1:0][fcld_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [fcld_pkg::DEBOUNCE_W-1:0]    debounce_ff, debounce_in;

   // Output buffer
   fcld_pkg::result_type               out_ff, out_in;
   fcld_pkg::result_type               skid_ff, skid_in;
   logic                               out_valid_ff, out_valid_in;
   logic                               skid_valid_ff, skid_valid_in;

   fcld_pkg::result_type               tick_result;
   logic [CH-1:0]                      fault_vec;
   logic                               req_take;
   logic                               rsp_take;
   logic                               csr_write;
   logic [fcld_pkg::COUNT_W-1:0]       cnt;
   logic                               sett;

   // Handshakes
   assign req_chan.ready = !skid_valid_ff;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_chan.valid && rsp_chan.ready;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      debounce_in = debounce_ff;
      if (csr_write && (csr_paddr[2] == fcld_pkg::REG_DEBOUNCE_TICKS)) begin
         debounce_in = csr_pwdata[fcld_pkg::DEBOUNCE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == fcld_pkg::REG_DEBOUNCE_TICKS) begin
         csr_prdata = {{(fcld_pkg::CSR_DATA_W-fcld_pkg::DEBOUNCE_W){1'b0}}, debounce_ff};
      end
   end

   // Per-channel tick update; channels are independent
   always_comb begin
      sampled_in  = sampled_ff;
      stable_in   = stable_ff;
      settling_in = settling_ff;
      count_in    = count_ff;
      fault_vec   = '0;
      for (int c = 0; c < CH; c++) begin
         cnt  = (count_ff[c] == fcld_pkg::COUNT_MAX) ? count_ff[c]
                                                     : count_ff[c] + 1'b1;
         sett = settling_ff[c] | req_chan.wake_event;
         if (sett) begin
            if (req_chan.raw_levels[c] != sampled_ff[c]) begin
               sampled_in[c] = req_chan.raw_levels[c];
               cnt           = '0;
            end
            if (cnt >= debounce_ff) begin
               stable_in[c] = sampled_in[c];
               fault_vec[c] = sampled_in[c] & ~stable_ff[c];
               sett         = 1'b0;
            end
         end
         if (req_take) begin
            count_in[c]    = cnt;
            settling_in[c] = sett;
         end else begin
            sampled_in[c]  = sampled_ff[c];
            stable_in[c]   = stable_ff[c];
         end
      end
   end

   always_comb begin
      tick_result.debounced_levels = stable_in;
      tick_result.fault_channels   = fault_vec;
      tick_result.fault            = |fault_vec;
      tick_result.settling_mask    = settling_in;
   end

   // Result register plus skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = req_take;
            skid_in       = tick_result;
         end else begin
            out_in        = tick_result;
            out_valid_in  = req_take;
         end
      end else if (req_take) begin
         if (!out_valid_ff) begin
            out_in       = tick_result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = tick_result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sampled_ff    <= '0;
         stable_ff     <= '0;
         settling_ff   <= '0;
         count_ff      <= '0;
         debounce_ff   <= fcld_pkg::DEBOUNCE_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         sampled_ff    <= sampled_in;
         stable_ff     <= stable_in;
         settling_ff   <= settling_in;
         count_ff      <= count_in;
         debounce_ff   <= debounce_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.debounced_levels = out_ff.debounced_levels;
   assign rsp_chan.fault_channels   = out_ff.fault_channels;
   assign rsp_chan.fault            = out_ff.fault;
   assign rsp_chan.settling_mask    = out_ff.settling_mask;

   // Checks
   `FCLD_ASSERT_ALWAYS(a_skid_behind_out, clock, reset,
      !skid_valid_ff || out_valid_ff,
      "skid entry valid while result register empty")
   `FCLD_ASSERT_ALWAYS(a_fault_is_rise, clock, reset,
      !out_valid_ff || ((out_ff.fault_channels & ~out_ff.debounced_levels) == '0),
      "fault on a channel whose debounced level is low")
   `FCLD_ASSERT_ALWAYS(a_fault_done_settling, clock, reset,
      !out_valid_ff || ((out_ff.fault_channels & out_ff.settling_mask) == '0),
      "fault on a channel still settling")
   `FCLD_ASSERT_NEXT(a_empty_fills, clock, reset,
      req_take && !out_valid_ff, out_valid_ff,
      "accepted tick into empty buffer did not appear")

endmodule

// ----- tb/tb_four_channel_limit_debounce.sv -----
// Self-checking testbench for the four-channel limit-switch debouncer.
module tb_four_channel_limit_debounce;

   localparam int CHANNELS   = fcld_pkg::CHANNELS;
   localparam int COUNT_W    = fcld_pkg::COUNT_W;
   localparam int DEBOUNCE_W = fcld_pkg::DEBOUNCE_W;
   localparam int CSR_DATA_W = fcld_pkg::CSR_DATA_W;
   localparam int CSR_ADDR_W = fcld_pkg::CSR_ADDR_W;

   localparam int CYCLE_LIMIT = 500000;
   localparam logic [CSR_ADDR_W-1:0] ADDR_DEBOUNCE = {fcld_pkg::REG_DEBOUNCE_TICKS, 2'b00};
   // Byte address of register index 1, which does not exist
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED = 3'b100;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      logic [CSR_ADDR_W-1:0]    addr;
      logic [CSR_DATA_W-1:0]    data;
      logic [CHANNELS-1:0]      raw;
      logic                     wake;
      bit                       typed;
      fcld_pkg::result_type     status;
   } plan_row_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   fcld_req_if tick_bus ();
   fcld_rsp_if status_bus ();

   four_channel_limit_debounce dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (tick_bus),
      .rsp_chan    (status_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Debouncer shadow state
   bit                  shadow_sampled [CHANNELS];
   bit                  shadow_stable  [CHANNELS];
   bit                  shadow_settling[CHANNELS];
   logic [COUNT_W-1:0]  shadow_age     [CHANNELS];
   logic [DEBOUNCE_W-1:0] shadow_debounce;

   fcld_pkg::result_type expected_status[$];
   plan_row_type         directed_plan[$];

   int mismatches;
   int ticks_sent;
   int statuses_checked;
   int faults_seen;
   int settings_written;
   int cycles;
   int send_burst_left;
   int stall_left;
   int calm_left;
   bit hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the shadow debouncer by one tick and return its status
   function automatic fcld_pkg::result_type debounce_tick(input logic [CHANNELS-1:0] raw,
                                                          input logic wake);
      fcld_pkg::result_type r;
      r = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (shadow_age[c] != fcld_pkg::COUNT_MAX) shadow_age[c]++;
         if (wake) shadow_settling[c] = 1'b1;
         if (shadow_settling[c]) begin
            if (raw[c] != shadow_sampled[c]) begin
               shadow_sampled[c] = raw[c];
               shadow_age[c] = '0;
            end
            if (shadow_age[c] >= shadow_debounce) begin
               if (shadow_sampled[c] && !shadow_stable[c]) r.fault_channels[c] = 1'b1;
               shadow_stable[c] = shadow_sampled[c];
               shadow_settling[c] = 1'b0;
            end
         end
         r.debounced_levels[c] = shadow_stable[c];
         r.settling_mask[c] = shadow_settling[c];
      end
      r.fault = |r.fault_channels;
      return r;
   endfunction

   function automatic bit log_mismatch();
      mismatches++;
      return mismatches <= 10;
   endfunction

   // Sender gap: mostly none or short, a few long, with runs of back-to-back ticks
   function automatic int sender_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (send_burst_left > 0) begin
         send_burst_left--;
         return 0;
      end
      if (roll < 2) begin
         send_burst_left = $urandom_range(30, 100);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   task automatic add_tick(input logic [CHANNELS-1:0] raw, input logic wake, input bit typed,
                           input logic [CHANNELS-1:0] levels, input logic [CHANNELS-1:0] faults,
                           input logic [CHANNELS-1:0] busy);
      plan_row_type row;
      row = '{kind: ROW_TICK, addr: '0, data: '0, raw: raw, wake: wake, typed: typed,
              status: '0};
      row.status.debounced_levels = levels;
      row.status.fault_channels = faults;
      row.status.fault = |faults;
      row.status.settling_mask = busy;
      directed_plan.push_back(row);
   endtask

   task automatic add_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      plan_row_type row;
      row = '{kind: ROW_WRITE, addr: addr, data: data, raw: '0, wake: 1'b0, typed: 1'b0,
              status: '0};
      directed_plan.push_back(row);
   endtask

   // Offer one tick and hold it until accepted; valid stays high on return
   task automatic drive_tick(input logic [CHANNELS-1:0] raw, input logic wake, input bit typed,
                             input fcld_pkg::result_type typed_status);
      fcld_pkg::result_type predicted;
      tick_bus.valid <= 1'b1;
      tick_bus.raw_levels <= raw;
      tick_bus.wake_event <= wake;
      @(posedge clock);
      while (!tick_bus.ready) @(posedge clock);
      predicted = debounce_tick(raw, wake);
      expected_status.push_back(typed ? typed_status : predicted);
      ticks_sent++;
   endtask

   task automatic idle_sender(input int gap);
      if (gap > 0) begin
         tick_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering ticks and let every outstanding status come back
   task automatic drain_results();
      tick_bus.valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // APB write while idle, then read the debounce register back
   task automatic program_register(input logic [CSR_ADDR_W-1:0] addr,
                                   input logic [CSR_DATA_W-1:0] data);
      drain_results();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_DEBOUNCE) shadow_debounce = data[DEBOUNCE_W-1:0];
      settings_written++;
      // read-back transfer follows directly
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_DEBOUNCE;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[DEBOUNCE_W-1:0] !== shadow_debounce)
         if (log_mismatch())
            $display("debounce_ticks read-back: expected %0d, got %0d",
                     shadow_debounce, csr_prdata[DEBOUNCE_W-1:0]);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Status receiver: random stalls, calm stretches, and one long hold on request
   always @(posedge clock) begin
      int roll;
      roll = $urandom_range(0, 99);
      if (hold_request) begin
         hold_request = 1'b0;
         stall_left = 80;
      end
      if (stall_left > 0) begin
         stall_left--;
         status_bus.ready <= 1'b0;
      end else if (calm_left > 0) begin
         calm_left--;
         status_bus.ready <= 1'b1;
      end else begin
         if (roll < 2) calm_left = $urandom_range(30, 100);
         else if (roll < 5) stall_left = $urandom_range(8, 30);
         else if (roll < 25) stall_left = $urandom_range(1, 3);
         status_bus.ready <= (stall_left == 0);
      end
   end

   // Compare each accepted status transaction with the oldest prediction
   always @(posedge clock) begin
      fcld_pkg::result_type seen;
      fcld_pkg::result_type want;
      if (!reset && status_bus.valid && status_bus.ready) begin
         seen.debounced_levels = status_bus.debounced_levels;
         seen.fault_channels = status_bus.fault_channels;
         seen.fault = status_bus.fault;
         seen.settling_mask = status_bus.settling_mask;
         if (expected_status.size() == 0) begin
            if (log_mismatch())
               $display("status transaction with no tick outstanding: lv=%h flt=%h f=%b set=%h",
                        seen.debounced_levels, seen.fault_channels, seen.fault,
                        seen.settling_mask);
         end else begin
            want = expected_status.pop_front();
            statuses_checked++;
            if (want.fault) faults_seen++;
            if (seen.debounced_levels !== want.debounced_levels ||
                seen.fault_channels !== want.fault_channels ||
                seen.fault !== want.fault || seen.settling_mask !== want.settling_mask)
               if (log_mismatch())
                  $display("status %0d: expected lv=%h flt=%h f=%b set=%h, got lv=%h flt=%h f=%b set=%h",
                           statuses_checked, want.debounced_levels, want.fault_channels,
                           want.fault, want.settling_mask, seen.debounced_levels,
                           seen.fault_channels, seen.fault, seen.settling_mask);
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d statuses outstanding",
                  cycles, expected_status.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int setting;
      int items;
      int change_odds;
      int bounce_left;
      logic [CHANNELS-1:0] target;
      logic [CHANNELS-1:0] raw;
      logic wake;

      reset = 1'b1;
      tick_bus.valid = 1'b0;
      tick_bus.raw_levels = '0;
      tick_bus.wake_event = 1'b0;
      status_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mismatches = 0;
      ticks_sent = 0;
      statuses_checked = 0;
      faults_seen = 0;
      settings_written = 0;
      cycles = 0;
      send_burst_left = 0;
      stall_left = 0;
      calm_left = 0;
      hold_request = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         shadow_sampled[c] = 1'b0;
         shadow_stable[c] = 1'b0;
         shadow_settling[c] = 1'b0;
         shadow_age[c] = '0;
      end
      shadow_debounce = fcld_pkg::DEBOUNCE_RESET;

      // Directed plan; typed statuses follow from the reset state by hand
      add_tick(4'hF, 1'b0, 1'b1, 4'h0, 4'h0, 4'h0);   // idle channels ignore raw levels
      add_write(ADDR_DEBOUNCE, 32'h0000_0001);
      add_tick(4'hF, 1'b1, 1'b1, 4'h0, 4'h0, 4'hF);   // wake: change recorded, count restarts
      add_tick(4'hF, 1'b0, 1'b1, 4'hF, 4'hF, 4'h0);   // accepted rise on all channels
      add_tick(4'h0, 1'b0, 1'b1, 4'hF, 4'h0, 4'h0);
      add_write(ADDR_UNMAPPED, 32'h0000_0000);        // unknown index, must be ignored
      add_tick(4'h0, 1'b1, 1'b1, 4'hF, 4'h0, 4'hF);
      add_tick(4'h5, 1'b0, 1'b1, 4'h5, 4'h0, 4'h5);   // bounce on channels 0 and 2
      add_tick(4'h0, 1'b0, 1'b1, 4'h5, 4'h0, 4'h5);
      add_tick(4'h0, 1'b0, 1'b1, 4'h0, 4'h0, 4'h0);
      add_write(ADDR_DEBOUNCE, 32'h0000_0000);        // zero setting: accept on the same tick
      add_tick(4'hA, 1'b1, 1'b1, 4'hA, 4'hA, 4'h0);
      add_tick(4'hF, 1'b0, 1'b1, 4'hA, 4'h0, 4'h0);
      add_tick(4'hF, 1'b1, 1'b1, 4'hF, 4'h5, 4'h0);
      add_tick(4'h0, 1'b1, 1'b1, 4'h0, 4'h0, 4'h0);
      add_tick(4'h8, 1'b1, 1'b1, 4'h8, 4'h8, 4'h0);
      add_tick(4'h8, 1'b1, 1'b1, 4'h8, 4'h0, 4'h0);   // already high: no second fault
      add_write(ADDR_DEBOUNCE, 32'hFFFF_FFFF);        // largest setting, upper bits set
      add_tick(4'h1, 1'b1, 1'b0, '0, '0, '0);
      add_tick(4'hE, 1'b0, 1'b0, '0, '0, '0);
      add_tick(4'hF, 1'b0, 1'b0, '0, '0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_WRITE) begin
            program_register(directed_plan[i].addr, directed_plan[i].data);
         end else begin
            drive_tick(directed_plan[i].raw, directed_plan[i].wake, directed_plan[i].typed,
                       directed_plan[i].status);
            idle_sender(sender_gap());
         end
      end

      // Random phases, one debounce setting each
      target = '0;
      bounce_left = 0;
      for (int phase = 0; phase < 6; phase++) begin
         items = 300;
         case (phase)
            0: setting = 10;
            1: setting = 1;
            2: setting = 0;
            3: begin
               setting = 255;
               items = 500;
            end
            4: setting = $urandom_range(2, 40);
            default: setting = 3;
         endcase
         program_register(ADDR_DEBOUNCE, ($urandom & 32'hFFFF_FF00) | setting);
         change_odds = (setting > 60 ? 60 : setting) * 2 + 4;
         for (int i = 0; i < items; i++) begin
            // long receiver hold while ticks keep coming back to back
            if (phase == 0 && i == 100) begin
               hold_request = 1'b1;
               send_burst_left = 24;
            end
            if (phase == 4 && i == 150) drain_results();
            // mostly clean switch changes with bounce; some noise and stray wakes
            if ($urandom_range(0, change_odds - 1) == 0) begin
               target = 4'($urandom_range(0, 15));
               bounce_left = $urandom_range(0, 4);
               wake = ($urandom_range(0, 7) != 0);
            end else begin
               wake = ($urandom_range(0, 24) == 0);
            end
            raw = target;
            if (bounce_left > 0) begin
               raw = target ^ 4'($urandom_range(1, 15));
               bounce_left--;
            end else if ($urandom_range(0, 39) == 0) begin
               raw = 4'($urandom_range(0, 15));
            end
            drive_tick(raw, wake, 1'b0, '0);
            idle_sender(sender_gap());
         end
      end

      drain_results();
      repeat (5) @(posedge clock);
      $display("Sent %0d ticks across %0d register writes; %0d statuses checked, %0d with faults",
               ticks_sent, settings_written, statuses_checked, faults_seen);
      $display("Debounce settings included 0, 1 and 255; %0d mismatches", mismatches);
      if (mismatches == 0 && expected_status.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fcld_pkg.sv
rtl/fcld_req_if.sv
rtl/fcld_rsp_if.sv
rtl/four_channel_limit_debounce.sv
tb/tb_four_channel_limit_debounce.sv
